[rtl/core/tcw_pkg.sv]
package tcw_pkg;

  // Screen geometry.
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int LAST_ROW_BASE = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;

  // Derived widths for the cursor, the linear index and the screen RAM address.
  localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
  localparam int COL_W   = $clog2(SCREEN_WIDTH + 1);
  localparam int LIN_W   = $clog2(CELL_COUNT + 1);
  localparam int CELL_AW = $clog2(CELL_COUNT);
  localparam int CELL_W  = 16;

  // Widths of the transaction fields.
  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int CURSOR_W = 11;
  localparam int COLOR_W  = 4;

  // Configuration port.
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  typedef enum logic [0:0] {
    REG_FORE = 1'b0,
    REG_BACK = 1'b1
  } cfg_reg_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

  // A blank cell is a space, white on black, whatever the colour registers hold.
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

endpackage

[rtl/core/tcw_if.sv]
// Command channel: one console operation per transaction.
interface tcw_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::OPCODE_W-1:0]  opcode;
  logic [tcw_pkg::CHAR_W-1:0]    char_code;
  logic [tcw_pkg::ADDR_W-1:0]    cell_address;

  modport source (output valid, output opcode, output char_code, output cell_address,
                  input ready);
  modport sink (input valid, input opcode, input char_code, input cell_address,
                output ready);
endinterface

// Response channel: one result per command.
interface tcw_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::CURSOR_W-1:0]  cursor_position;
  logic [tcw_pkg::CHAR_W-1:0]    read_char;
  logic [tcw_pkg::CHAR_W-1:0]    read_color;

  modport source (output valid, output cursor_position, output read_char,
                  output read_color, input ready);
  modport sink (input valid, input cursor_position, input read_char,
                input read_color, output ready);
endinterface

[rtl/core/text_console_writer.sv]
// A put that does not scroll, an unused opcode or an out-of-range read goes from S_IDLE to S_HOLD
// and then to the output register; an in-range read passes S_READ first. A clear sweeps the
// screen RAM; a newline or a wrapping put on the last row scrolls it and blanks the last row,
// all through the single RAM write port. Only one command is in flight at a time.
// Reset puts the cursor at row 0, column 0 and the colours at white on black;
// the screen RAM keeps its contents and reads as undefined until the first clear.
module text_console_writer (
  input  logic                       clk,
  input  logic                       rst,
  tcw_in_if.sink                     cmd,
  tcw_out_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcw_pkg::CFG_AW-1:0] paddr,
  input  logic [tcw_pkg::CFG_DW-1:0] pwdata,
  output logic [tcw_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_BLANK  = 5'b01000,
    S_HOLD   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [tcw_pkg::ROW_W-1:0]   cur_row;
  logic [tcw_pkg::COL_W-1:0]   cur_col;
  logic [tcw_pkg::COLOR_W-1:0] fore_color;
  logic [tcw_pkg::COLOR_W-1:0] back_color;

  logic [tcw_pkg::CHAR_W-1:0]  pend_ch;
  logic                        pend_char;
  logic [tcw_pkg::LIN_W-1:0]   rd_addr;
  logic                        mv_vld;
  logic [tcw_pkg::CELL_AW-1:0] mv_wr;
  logic [tcw_pkg::CELL_AW-1:0] bk_addr;
  logic [tcw_pkg::CHAR_W-1:0]  res_char;
  logic [tcw_pkg::CHAR_W-1:0]  res_color;

  logic                         out_valid;
  logic [tcw_pkg::CURSOR_W-1:0] out_pos;
  logic [tcw_pkg::CHAR_W-1:0]   out_char;
  logic [tcw_pkg::CHAR_W-1:0]   out_color;

  logic                        ram_we;
  logic [tcw_pkg::CELL_AW-1:0] ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
  logic [tcw_pkg::CELL_AW-1:0] ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

  logic                        accept;
  logic                        is_nl;
  logic                        is_bs;
  logic                        at_last;
  logic                        row_full;
  logic                        col_zero;
  logic                        addr_ok;
  logic                        scroll_done;
  logic                        out_free;
  logic [tcw_pkg::ROW_W-1:0]   put_row;
  logic [tcw_pkg::COL_W-1:0]   put_col;
  logic [tcw_pkg::LIN_W-1:0]   put_addr;
  logic [tcw_pkg::LIN_W-1:0]   cursor_lin;
  logic [tcw_pkg::CHAR_W-1:0]  color_byte;

  // Screen memory.
  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELL_COUNT)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshakes and the configuration port.
  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid           = out_valid;
  assign rsp.cursor_position = out_pos;
  assign rsp.read_char       = out_char;
  assign rsp.read_color      = out_color;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[2:2])
      tcw_pkg::REG_BACK: prdata = tcw_pkg::CFG_DW'(back_color);
      default:           prdata = tcw_pkg::CFG_DW'(fore_color);
    endcase
  end

  // Decode of the put command against the current cursor.
  assign is_nl      = (cmd.char_code == tcw_pkg::CH_NEWLINE);
  assign is_bs      = (cmd.char_code == tcw_pkg::CH_BACKSPACE);
  assign at_last    = (cur_row >= tcw_pkg::ROW_W'(tcw_pkg::SCREEN_HEIGHT - 1));
  assign row_full   = (cur_col >= tcw_pkg::COL_W'(tcw_pkg::SCREEN_WIDTH));
  assign col_zero   = (cur_col == '0);
  assign addr_ok    = (int'(cmd.cell_address) < tcw_pkg::CELL_COUNT);
  assign color_byte = {back_color, fore_color};

  // Target cell of a put: one left for backspace, start of the next row on a wrap.
  always_comb begin
    put_row = cur_row;
    put_col = cur_col;
    if (is_bs) begin
      put_col = cur_col - tcw_pkg::COL_W'(1);
    end else if (row_full) begin
      put_row = cur_row + tcw_pkg::ROW_W'(1);
      put_col = '0;
    end
  end

  assign put_addr   = tcw_pkg::LIN_W'(put_row) * tcw_pkg::LIN_W'(tcw_pkg::SCREEN_WIDTH)
                    + tcw_pkg::LIN_W'(put_col);
  assign cursor_lin = tcw_pkg::LIN_W'(cur_row) * tcw_pkg::LIN_W'(tcw_pkg::SCREEN_WIDTH)
                    + tcw_pkg::LIN_W'(cur_col);

  assign scroll_done = (rd_addr == tcw_pkg::LIN_W'(tcw_pkg::CELL_COUNT)) && mv_vld;

  // RAM port selection for each state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bk_addr;
    ram_wdata = tcw_pkg::BLANK_CELL;
    ram_raddr = tcw_pkg::CELL_AW'(cmd.cell_address);
    case (state)
      S_IDLE: begin
        if (accept && cmd.opcode == tcw_pkg::OP_PUT) begin
          if (is_bs) begin
            ram_we = !col_zero;
          end else if (!is_nl) begin
            ram_we = !(row_full && at_last);
          end
          ram_waddr = tcw_pkg::CELL_AW'(put_addr);
          ram_wdata = is_bs ? tcw_pkg::BLANK_CELL : {color_byte, cmd.char_code};
        end
      end
      S_SCROLL: begin
        // Read a row ahead and write the data in the next cycle, a row lower in address.
        ram_raddr = tcw_pkg::CELL_AW'(rd_addr);
        ram_we    = mv_vld;
        ram_waddr = mv_wr;
        ram_wdata = ram_rdata;
      end
      S_BLANK: begin
        ram_we = 1'b1;
        if (pend_char && bk_addr == tcw_pkg::CELL_AW'(tcw_pkg::LAST_ROW_BASE)) begin
          ram_wdata = {color_byte, pend_ch};
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.opcode)
            tcw_pkg::OP_PUT: begin
              if ((is_nl || (!is_bs && row_full)) && at_last) begin
                state_next = S_SCROLL;
              end else begin
                state_next = S_HOLD;
              end
            end
            tcw_pkg::OP_CLEAR: state_next = S_BLANK;
            tcw_pkg::OP_READ:  state_next = addr_ok ? S_READ : S_HOLD;
            default:           state_next = S_HOLD;
          endcase
        end
      end
      S_READ: state_next = S_HOLD;
      S_SCROLL: begin
        if (scroll_done) begin
          state_next = S_BLANK;
        end
      end
      S_BLANK: begin
        if (bk_addr == tcw_pkg::CELL_AW'(tcw_pkg::CELL_COUNT - 1)) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state, cursor and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_row    <= '0;
      cur_col    <= '0;
      fore_color <= tcw_pkg::COLOR_W'(15);
      back_color <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (psel && penable && pwrite) begin
        case (paddr[2:2])
          tcw_pkg::REG_BACK: back_color <= pwdata[tcw_pkg::COLOR_W-1:0];
          default:           fore_color <= pwdata[tcw_pkg::COLOR_W-1:0];
        endcase
      end

      if (state == S_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (state == S_IDLE && accept && cmd.opcode == tcw_pkg::OP_PUT) begin
        if (is_nl) begin
          cur_col <= '0;
          if (!at_last) begin
            cur_row <= cur_row + tcw_pkg::ROW_W'(1);
          end
        end else if (is_bs) begin
          if (!col_zero) begin
            cur_col <= put_col;
          end
        end else if (row_full && at_last) begin
          // The character lands at column 0 of the last row after the scroll.
          cur_col <= tcw_pkg::COL_W'(1);
        end else begin
          cur_row <= put_row;
          cur_col <= put_col + tcw_pkg::COL_W'(1);
        end
      end
    end
  end

  // Sweep counters, pending character and result registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_char  <= '0;
          res_color <= '0;
          pend_char <= (cmd.opcode != tcw_pkg::OP_CLEAR) && !is_nl && !is_bs;
          pend_ch   <= cmd.char_code;
          rd_addr   <= tcw_pkg::LIN_W'(tcw_pkg::SCREEN_WIDTH);
          mv_vld    <= 1'b0;
          mv_wr     <= '0;
          if (cmd.opcode == tcw_pkg::OP_CLEAR) begin
            bk_addr <= '0;
          end else begin
            bk_addr <= tcw_pkg::CELL_AW'(tcw_pkg::LAST_ROW_BASE);
          end
        end
      end
      S_READ: begin
        res_char  <= ram_rdata[tcw_pkg::CHAR_W-1:0];
        res_color <= ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
      end
      S_SCROLL: begin
        if (rd_addr < tcw_pkg::LIN_W'(tcw_pkg::CELL_COUNT)) begin
          rd_addr <= rd_addr + tcw_pkg::LIN_W'(1);
        end
        mv_vld <= (rd_addr < tcw_pkg::LIN_W'(tcw_pkg::CELL_COUNT));
        if (mv_vld) begin
          mv_wr <= mv_wr + tcw_pkg::CELL_AW'(1);
        end
      end
      S_BLANK: begin
        bk_addr <= bk_addr + tcw_pkg::CELL_AW'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register, loaded once the result slot is free.
  always_ff @(posedge clk) begin
    if (state == S_HOLD && out_free) begin
      out_pos   <= tcw_pkg::CURSOR_W'(cursor_lin);
      out_char  <= res_char;
      out_color <= res_color;
    end
  end

endmodule

[rtl/core/tcw_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/tcw_checker.sv]
module tcw_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [tcw_pkg::CURSOR_W-1:0] rsp_cursor_position,
  input logic [tcw_pkg::CHAR_W-1:0]   rsp_read_char,
  input logic [tcw_pkg::CHAR_W-1:0]   rsp_read_color
);

  // A stalled result keeps its contents until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_position)
      && $stable(rsp_read_char) && $stable(rsp_read_color))
    else $error("result changed while stalled");

  // Only one command is in flight: acceptance closes the command channel.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted while another is in flight");

  // A new result is only presented after the command channel was closed.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(cmd_ready))
    else $error("result appeared without a command in progress");

  // Reset empties the result channel.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk                 (clk),
  .rst                 (rst),
  .cmd_valid           (cmd.valid),
  .cmd_ready           (cmd.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_cursor_position (rsp.cursor_position),
  .rsp_read_char       (rsp.read_char),
  .rsp_read_color      (rsp.read_color)
);

[tb/sv/tb_text_console_writer.sv]
module tb_text_console_writer;
  import tcw_pkg::*;

  // The opcode that the block must accept and otherwise ignore.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // A clear or a scroll sweeps the whole screen RAM. At most about 1100 commands, each at
  // the cost of a sweep plus the longest gap on both sides, stay far below this guard.
  localparam int CYCLE_LIMIT     = 20_000_000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS     = 90;
  localparam int PHASES          = 5;
  localparam int MAX_REPORTED    = 10;
  localparam int ADDR_TOP        = (1 << ADDR_W) - 1;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CHAR_W-1:0]   chr;
    logic [CHAR_W-1:0]   colour;
  } console_result_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [CHAR_W-1:0]   ch;
    logic [ADDR_W-1:0]   addr;
    logic [7:0]          reps;
    logic                fixed;
    console_result_t     want;
  } stim_row_t;

  localparam console_result_t NO_WANT = '0;

  // Directed rows. Where fixed is set the expected result is written out here;
  // the other rows are checked against the screen model.
  localparam stim_row_t DIRECTED_ROWS [0:24] = '{
    // A put straight after reset lands at the home position.
    '{OP_PUT,    8'h41,        11'd0,    8'd1,  1'b1, '{11'd1, 8'h00, 8'h00}},
    // An out-of-range read touches no cell and answers zero.
    '{OP_READ,   8'h00,        11'd2047, 8'd1,  1'b1, '{11'd1, 8'h00, 8'h00}},
    // Clear leaves the cursor where it is.
    '{OP_CLEAR,  8'h00,        11'd0,    8'd1,  1'b1, '{11'd1, 8'h00, 8'h00}},
    '{OP_READ,   8'h00,        11'd0,    8'd1,  1'b1,
      '{11'd1, BLANK_CELL[7:0], BLANK_CELL[15:8]}},
    '{OP_READ,   8'hFF,        11'd1999, 8'd1,  1'b1,
      '{11'd1, BLANK_CELL[7:0], BLANK_CELL[15:8]}},
    '{OP_READ,   8'h00,        11'd2000, 8'd1,  1'b1, '{11'd1, 8'h00, 8'h00}},
    // Backspace from column 1, then backspace at column 0, which does nothing.
    '{OP_PUT,    CH_BACKSPACE, 11'd0,    8'd1,  1'b1, '{11'd0, 8'h00, 8'h00}},
    '{OP_PUT,    CH_BACKSPACE, 11'd2047, 8'd1,  1'b1, '{11'd0, 8'h00, 8'h00}},
    // Character code extremes.
    '{OP_PUT,    8'h00,        11'd0,    8'd1,  1'b1, '{11'd1, 8'h00, 8'h00}},
    '{OP_PUT,    8'hFF,        11'd2047, 8'd1,  1'b0, NO_WANT},
    '{OP_PUT,    8'h7F,        11'd0,    8'd1,  1'b0, NO_WANT},
    '{OP_PUT,    8'h80,        11'd0,    8'd1,  1'b0, NO_WANT},
    '{OP_READ,   8'h00,        11'd1,    8'd1,  1'b0, NO_WANT},
    // The unused opcode only reports the cursor.
    '{OP_UNUSED, 8'hFF,        11'd2047, 8'd1,  1'b1, '{11'd4, 8'h00, 8'h00}},
    '{OP_READ,   8'h00,        11'd3,    8'd1,  1'b0, NO_WANT},
    // Walk down to the last row and keep going, so that the screen scrolls.
    '{OP_PUT,    CH_NEWLINE,   11'd0,    8'd30, 1'b0, NO_WANT},
    // Fill the last row, back up once from the full row, then wrap.
    '{OP_PUT,    8'h57,        11'd0,    8'd80, 1'b0, NO_WANT},
    '{OP_PUT,    CH_BACKSPACE, 11'd0,    8'd1,  1'b0, NO_WANT},
    '{OP_PUT,    8'h5A,        11'd0,    8'd2,  1'b0, NO_WANT},
    '{OP_READ,   8'h00,        11'd1919, 8'd1,  1'b0, NO_WANT},
    '{OP_READ,   8'h00,        11'd1920, 8'd1,  1'b0, NO_WANT},
    '{OP_UNUSED, 8'h00,        11'd0,    8'd1,  1'b0, NO_WANT},
    '{OP_CLEAR,  8'hFF,        11'd2047, 8'd1,  1'b0, NO_WANT},
    '{OP_READ,   8'h00,        11'd1999, 8'd1,  1'b0, NO_WANT},
    '{OP_PUT,    CH_NEWLINE,   11'd0,    8'd1,  1'b0, NO_WANT}
  };

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  tcw_in_if  cmd_if ();
  tcw_out_if rsp_if ();

  text_console_writer u_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Screen model: cell memory, cursor and colour registers.
  logic [CELL_W-1:0]  screen_model [CELL_COUNT];
  int unsigned        cur_row  = 0;
  int unsigned        cur_col  = 0;
  logic [COLOR_W-1:0] fore_nib = 4'hF;
  logic [COLOR_W-1:0] back_nib = 4'h0;

  console_result_t    pending_results [$];
  int                 mismatch_count = 0;
  int unsigned        cmds_sent      = 0;
  int unsigned        send_idle_pct  = 20;
  int unsigned        recv_idle_pct  = 20;
  bit                 hold_off_req   = 1'b0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Moves the model cursor to the next line, scrolling when it is on the last row.
  function automatic void next_line();
    if (cur_row >= SCREEN_HEIGHT - 1) begin
      for (int i = 0; i < LAST_ROW_BASE; i++) screen_model[i] = screen_model[i + SCREEN_WIDTH];
      for (int i = LAST_ROW_BASE; i < CELL_COUNT; i++) screen_model[i] = BLANK_CELL;
    end else begin
      cur_row++;
    end
    cur_col = 0;
  endfunction

  // Applies one command to the screen model and returns the result it should give.
  function automatic console_result_t console_step(input logic [OPCODE_W-1:0] op,
                                                   input logic [CHAR_W-1:0]   ch,
                                                   input logic [ADDR_W-1:0]   addr);
    console_result_t res;
    res = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_NEWLINE) begin
          next_line();
        end else if (ch == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            screen_model[cur_row * SCREEN_WIDTH + cur_col] = BLANK_CELL;
          end
        end else begin
          // A full row wraps first; the character then goes to column 0.
          if (cur_col >= SCREEN_WIDTH) next_line();
          screen_model[cur_row * SCREEN_WIDTH + cur_col] = {back_nib, fore_nib, ch};
          cur_col++;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = BLANK_CELL;
      end
      OP_READ: begin
        if (addr < CELL_COUNT) begin
          res.chr    = screen_model[addr][7:0];
          res.colour = screen_model[addr][15:8];
        end
      end
      default: begin
      end
    endcase
    res.cursor = CURSOR_W'(cur_row * SCREEN_WIDTH + cur_col);
    return res;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED)
      $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
  endfunction

  // Offers one command transaction, with an occasional gap before it, and
  // records the expected result once it is accepted.
  task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                          input logic [ADDR_W-1:0] addr, input bit use_fixed = 1'b0,
                          input console_result_t fixed_want = '0);
    console_result_t predicted;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.opcode       <= op;
    cmd_if.char_code    <= ch;
    cmd_if.cell_address <= addr;
    do @(posedge clk); while (!cmd_if.ready);
    predicted = console_step(op, ch, addr);
    pending_results.push_back(use_fixed ? fixed_want : predicted);
    cmds_sent++;
  endtask

  // Stops offering commands and waits until every outstanding result has come.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one colour register over the configuration port and reads it back.
  task automatic program_colour(input cfg_reg_t idx, input logic [COLOR_W-1:0] val);
    logic [CFG_DW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * int'(idx));
    pwdata  <= CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Back-to-back read of the same register; psel stays high.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx == REG_FORE) fore_nib = val;
    else back_nib = val;
    if (readback[COLOR_W-1:0] !== val)
      flag_mismatch("colour register readback", 32'(val), readback);
  endtask

  // Random traffic, mostly lines of text with newlines, backspaces and reads,
  // with some fully random commands and the odd clear. Every cell has been
  // written by the first clear of the directed part, so any address may be read.
  task automatic run_random(input int unsigned target);
    int unsigned kind;
    int unsigned len;
    while (cmds_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 30);
        repeat (len)
          send_cmd(OP_PUT,
                   ($urandom_range(0, 7) == 0) ? CHAR_W'($urandom)
                                               : CHAR_W'($urandom_range(8'h20, 8'h7E)),
                   ADDR_W'($urandom));
        if ($urandom_range(0, 9) < 6) send_cmd(OP_PUT, CH_NEWLINE, ADDR_W'($urandom));
      end else if (kind < 65) begin
        repeat ($urandom_range(1, 4))
          send_cmd(OP_READ, CHAR_W'($urandom),
                   ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom_range(CELL_COUNT, ADDR_TOP))
                                               : ADDR_W'($urandom_range(0, CELL_COUNT - 1)));
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 5)) send_cmd(OP_PUT, CH_BACKSPACE, ADDR_W'($urandom));
      end else if (kind < 85) begin
        send_cmd(OP_PUT, CH_NEWLINE, ADDR_W'($urandom));
      end else if (kind < 97) begin
        repeat ($urandom_range(1, 3))
          send_cmd(OPCODE_W'($urandom), CHAR_W'($urandom), ADDR_W'($urandom));
      end else begin
        send_cmd(OP_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom));
      end
    end
  endtask

  // Response ready: random stall bursts, plus one long hold-off on request.
  initial begin : rsp_ready_driver
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(1, 18) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Each accepted result transaction is compared with the oldest expectation.
  initial begin : result_checker
    console_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with nothing outstanding, cursor_position", '0,
                        32'(rsp_if.cursor_position));
        end else begin
          want = pending_results.pop_front();
          if (rsp_if.cursor_position !== want.cursor)
            flag_mismatch("cursor_position", 32'(want.cursor), 32'(rsp_if.cursor_position));
          if (rsp_if.read_char !== want.chr)
            flag_mismatch("read_char", 32'(want.chr), 32'(rsp_if.read_char));
          if (rsp_if.read_color !== want.colour)
            flag_mismatch("read_color", 32'(want.colour), 32'(rsp_if.read_color));
        end
      end
    end
  end

  // Guard against a hung run.
  initial begin : cycle_guard
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** text_console_writer: FAILED **");
    $finish;
  end

  // Reset, directed rows, then random phases under different colours and pacing.
  initial begin : stimulus
    int fore_plan [PHASES] = '{0, 15, -1, 0, -1};
    int back_plan [PHASES] = '{0, 15, -1, 15, -1};
    int send_plan [PHASES] = '{30, 5, 40, 10, 0};
    int recv_plan [PHASES] = '{30, 15, 40, 10, 0};
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    cmd_if.valid        <= 1'b0;
    cmd_if.opcode       <= OP_PUT;
    cmd_if.char_code    <= '0;
    cmd_if.cell_address <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[r])
      repeat (DIRECTED_ROWS[r].reps)
        send_cmd(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].addr,
                 DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      // Colours change only while nothing is in flight.
      drain_results();
      program_colour(REG_FORE, (fore_plan[ph] < 0) ? COLOR_W'($urandom)
                                                   : COLOR_W'(fore_plan[ph]));
      program_colour(REG_BACK, (back_plan[ph] < 0) ? COLOR_W'($urandom)
                                                   : COLOR_W'(back_plan[ph]));
      send_idle_pct = send_plan[ph];
      recv_idle_pct = recv_plan[ph];
      // In the second phase the receiver holds off while commands keep coming.
      if (ph == 1) hold_off_req = 1'b1;
      run_random(cmds_sent + PHASE_ITEMS);
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("** text_console_writer: PASSED **");
    end else begin
      $display("** text_console_writer: FAILED **");
    end
    $finish;
  end

endmodule
